/* rtl/sorted_descending_table_defines.svh */
// Assertion macros for the sorted descending table RTL.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef SORTED_DESCENDING_TABLE_DEFINES_SVH
`define SORTED_DESCENDING_TABLE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SDT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted table check failed");

// Next-cycle implication, checked outside reset.
`define SDT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted table check failed");

`endif

/* rtl/sdt_pkg.sv */
// Package for the sorted descending table: command codes, status codes and
// the controller-to-datapath command struct. No dependencies.
package sdt_pkg;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_REMOVE = 3'd1,
        OP_SEARCH = 3'd2,
        OP_POP    = 3'd3,
        OP_PEEK   = 3'd4,
        OP_CLEAR  = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture a new command and key
        logic compare;  // register the per-cell compare flags
        logic update;   // apply the command to the store and results
    } dp_cmd_t;

endpackage

/* rtl/sorted_descending_table.sv */
// Sorted descending table, top level. A transaction is captured, compared,
// then applied in the update step; done rises once the update is registered.
// The next one is taken in that update step but not in the compare step, as
// the compare step and the update step both use the single row of value cells.
// Reset (rst_n, asynchronous, active low) empties the table and idles the
// controller; done is a one-cycle strobe and the receiver cannot stall it.
`include "sorted_descending_table_defines.svh"

module sorted_descending_table
    import sdt_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         op,
    input  logic signed [31:0] key,
    output logic               done,
    output logic [1:0]         status,
    output logic               found,
    output logic signed [31:0] value,
    output logic [4:0]         count
);

    // The controller steps each transaction through three phases:
    // capture (start taken while busy is low), compare, and update. The
    // next transaction may be captured in the same cycle as the update,
    // since the update works from the command captured earlier.
    dp_cmd_t dp_cmd;

    sdt_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (dp_cmd),
        .done  (done)
    );

    // The datapath holds the values in descending order, one per cell.
    // In the compare phase every cell registers whether it equals the key
    // and whether the key is at least as large as it. In the update phase
    // those flags steer each cell to keep its value, take its neighbor's
    // value, or take the key, so inserts and removals shift the whole row at once.
    sdt_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (dp_cmd),
        .op_in  (op),
        .key_in (key),
        .status (status),
        .found  (found),
        .value  (value),
        .count  (count)
    );

    // An accepted transaction always produces its result with done high.
    `SDT_ASSERT_NOW(a_done_follows_start, start && !busy, ##3 done)
    `SDT_ASSERT_NEXT(a_done_single, done, !done)
    // The controller is busy for exactly one cycle per transaction.
    `SDT_ASSERT_NEXT(a_busy_single, busy, !busy)
    // An empty report comes with a zero value and an empty table.
    `SDT_ASSERT_NOW(a_empty_result, done && (status == ST_EMPTY),
        (value == 32'sd0) && (count == 5'd0))

endmodule

/* rtl/sdt_ctrl.sv */
// Controller for the sorted descending table: sequences accept, compare and
// update steps for each transaction. Depends on sdt_pkg.
module sdt_ctrl
    import sdt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    output dp_cmd_t cmd,
    output logic    done
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_UPD  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   accept;

    // A new transaction may enter while the previous one is being applied.
    assign busy   = (state_reg == S_CMP);
    assign accept = start && !busy;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                state_next = start ? S_CMP : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign cmd.load    = accept;
    assign cmd.compare = (state_reg == S_CMP);
    assign cmd.update  = (state_reg == S_UPD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_UPD);
        end
    end

    assign done = done_reg;

endmodule

/* rtl/sdt_datapath.sv */
// Datapath for the sorted descending table: a row of value cells with local
// compare flags, shift logic, fill count and result registers. Uses sdt_pkg.
module sdt_datapath
    import sdt_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    input  logic [2:0]         op_in,
    input  logic signed [31:0] key_in,
    output logic [1:0]         status,
    output logic               found,
    output logic signed [31:0] value,
    output logic [4:0]         count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [2:0]         op_reg;
    logic signed [31:0] key_reg;
    logic signed [31:0] cell_reg [CAPACITY];
    logic signed [31:0] cell_next [CAPACITY];
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [CAPACITY-1:0] valid_reg;
    logic [CAPACITY-1:0] eq_reg;
    logic [CAPACITY-1:0] ge_reg;
    logic [CAPACITY-1:0] take;
    status_t            status_reg;
    status_t            status_next;
    logic               found_reg;
    logic               found_next;
    logic signed [31:0] value_reg;
    logic signed [31:0] value_next;
    logic               any_eq;
    logic               is_full;
    logic               is_empty;
    logic [CNT_W+4:0]   count_ext;

    // Command capture, per-cell compare flags, cell row and result registers (payload, no reset).
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= op_in;
            key_reg <= key_in;
        end
        if (cmd.compare)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                valid_reg[i] <= (CNT_W'(i) < count_reg);
                eq_reg[i]    <= (CNT_W'(i) < count_reg) && (cell_reg[i] == key_reg);
                ge_reg[i]    <= (CNT_W'(i) < count_reg) && !(cell_reg[i] > key_reg);
            end
        end
        if (cmd.update)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                cell_reg[i] <= cell_next[i];
            end
            status_reg <= status_next;
            found_reg  <= found_next;
            value_reg  <= value_next;
        end
    end

    assign any_eq   = |eq_reg;
    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);

    // The key goes ahead of every cell it beats and of every empty cell;
    // in a descending row this marks a suffix starting at the insert point.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            take[i] = (ge_reg[i] && !eq_reg[i]) || !valid_reg[i];
        end
    end

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_next[i] = cell_reg[i];
        end
        count_next  = count_reg;
        status_next = ST_OK;
        found_next  = 1'b0;
        value_next  = '0;
        unique case (op_reg)
            OP_INSERT:
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    if (take[0])
                    begin
                        cell_next[0] = key_reg;
                    end
                    for (int i = 1; i < CAPACITY; i++)
                    begin
                        if (take[i])
                        begin
                            cell_next[i] = take[i-1] ? cell_reg[i-1] : key_reg;
                        end
                    end
                    count_next = count_reg + 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (any_eq)
                begin
                    // Cells from the first match onward close the gap.
                    for (int i = 0; i < CAPACITY - 1; i++)
                    begin
                        if (ge_reg[i])
                        begin
                            cell_next[i] = cell_reg[i+1];
                        end
                    end
                    count_next = count_reg - 1'b1;
                    found_next = 1'b1;
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            OP_SEARCH:
            begin
                found_next = any_eq;
            end
            OP_POP, OP_PEEK:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    value_next = cell_reg[0];
                    if (op_reg == OP_POP)
                    begin
                        for (int i = 0; i < CAPACITY - 1; i++)
                        begin
                            cell_next[i] = cell_reg[i+1];
                        end
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            OP_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.update)
        begin
            count_reg <= count_next;
        end
    end

    assign count_ext = {5'b0, count_reg};
    assign count     = count_ext[4:0];
    assign status    = status_reg;
    assign found     = found_reg;
    assign value     = value_reg;

endmodule

/* tb/tb_sorted_descending_table.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the sorted descending table (sorted_descending_table).
// Depends on sdt_pkg for the command and status codes; it needs nothing but the RTL.

module tb_sorted_descending_table;
    import sdt_pkg::*;

    // Same depth as the block; the mirror below refuses inserts at this fill.
    localparam int TABLE_DEPTH = 16;

    // The op field is three bits wide, so codes 6 and 7 exist on the wire.
    // The block answers them as no-ops: status ok, nothing found, count unchanged.
    localparam logic [2:0] OP_UNUSED_6 = 3'd6;
    localparam logic [2:0] OP_UNUSED_7 = 3'd7;

    localparam int RANDOM_CMDS = 1350;
    // Cycles allowed after the last answer for anything stray to show up.
    localparam int SETTLE_CYCLES = 10;
    // The slowest correct run is about 1400 transactions, each with its gap,
    // a possible drain wait and its time in the block. The limit sits well
    // above the length of such a run.
    localparam int CYCLE_LIMIT = 500000;

    // One command waiting to be sent. The gap is the number of idle cycles
    // placed before it. The drain flag holds the command back until every
    // answer already owed by the block has come out.
    typedef struct {
        logic [2:0]         opc;
        logic signed [31:0] arg;
        int                 gap;
        bit                 drain;
    } table_cmd_t;

    // One answer as the block should report it.
    typedef struct packed {
        logic [1:0]         st;
        logic               hit;
        logic signed [31:0] val;
        logic [4:0]         cnt;
    } table_answer_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [2:0]         op = OP_INSERT;
    logic signed [31:0] key = '0;
    logic               done;
    logic [1:0]         status;
    logic               found;
    logic signed [31:0] value;
    logic [4:0]         count;

    table_cmd_t         cmd_q[$];       // commands not yet sent to the table
    table_answer_t      answer_q[$];    // answers owed by the table, oldest first
    logic signed [31:0] mirror_vals[$]; // the table contents, largest first
    int                 hold_cnt = 0;
    int                 cycle_cnt = 0;
    int                 errors = 0;

    sorted_descending_table #(
        .CAPACITY (TABLE_DEPTH)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .op     (op),
        .key    (key),
        .done   (done),
        .status (status),
        .found  (found),
        .value  (value),
        .count  (count)
    );

    always #5 clk = ~clk;

    // Apply one accepted command to the mirror and queue the answer that the
    // table owes for it. Values stay largest first. A new value goes after
    // every value that is equal to it or larger, so duplicates keep the order
    // in which they came in.
    task automatic apply_table_cmd(input logic [2:0] opc, input logic signed [31:0] arg);
        int            pos;
        table_answer_t ans;
        begin
            ans = '{st: ST_OK, hit: 1'b0, val: '0, cnt: '0};
            pos = 0;
            case (opc)
                OP_INSERT:
                begin
                    if (mirror_vals.size() >= TABLE_DEPTH)
                        ans.st = ST_FULL;
                    else
                    begin
                        while (pos < mirror_vals.size() && !(arg > mirror_vals[pos]))
                            pos++;
                        mirror_vals.insert(pos, arg);
                    end
                end
                OP_REMOVE, OP_SEARCH:
                begin
                    while (pos < mirror_vals.size() && mirror_vals[pos] != arg)
                        pos++;
                    if (pos < mirror_vals.size())
                    begin
                        ans.hit = 1'b1;
                        // Only the first matching copy goes away.
                        if (opc == OP_REMOVE)
                            mirror_vals.delete(pos);
                    end
                    else if (opc == OP_REMOVE)
                        ans.st = ST_NOT_FOUND;
                    // A search that misses still reports ok; only found is low.
                end
                OP_POP, OP_PEEK:
                begin
                    if (mirror_vals.size() == 0)
                        ans.st = ST_EMPTY;
                    else
                    begin
                        ans.val = mirror_vals[0];
                        if (opc == OP_POP)
                            mirror_vals.delete(0);
                    end
                end
                OP_CLEAR:
                    mirror_vals.delete();
                default:
                    ; // unused codes leave the table alone
            endcase
            ans.cnt = 5'(mirror_vals.size());
            answer_q.push_back(ans);
        end
    endtask

    // Idle cycles before a command: mostly none, often a few, now and then a
    // long pause. When calm is set the stream runs back to back.
    function automatic int pick_gap(input bit calm);
        int r;
        begin
            r = $urandom_range(0, 99);
            if (calm || r < 60)
                return 0;
            else if (r < 90)
                return $urandom_range(1, 3);
            else
                return $urandom_range(8, 40);
        end
    endfunction

    // Keys come mostly from a small pool, so inserts pile up duplicates and
    // removes and searches find something. The pool holds both extremes of
    // the signed range. The rest are full 32-bit random values, which toggle
    // every bit of the key.
    function automatic logic signed [31:0] pick_key();
        logic signed [31:0] pool[8];
        begin
            pool = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0, -32'sd1,
                     32'sd1, 32'sd5, -32'sd7, 32'sd100};
            if ($urandom_range(0, 99) < 70)
                return pool[$urandom_range(0, 7)];
            else
                return $urandom;
        end
    endfunction

    task automatic add_cmd(input logic [2:0] opc, input logic signed [31:0] arg,
                           input int gap, input bit drain);
        table_cmd_t c;
        begin
            c.opc   = opc;
            c.arg   = arg;
            c.gap   = gap;
            c.drain = drain;
            cmd_q.push_back(c);
        end
    endtask

    // Driver. A transaction is taken at an edge where start is high and busy
    // is low. At that edge the command that was on the pins goes into the
    // mirror. The next command is then presented right away, or start drops
    // while the gap of the next command runs out. start is assigned once per
    // edge, so a back-to-back stream simply keeps it high.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            op       <= OP_INSERT;
            key      <= '0;
            hold_cnt <= 0;
        end
        else
        begin
            if (start && !busy)
                apply_table_cmd(op, key);
            if (!start || !busy)
            begin
                if (cmd_q.size() == 0)
                    start <= 1'b0;
                else if (hold_cnt < cmd_q[0].gap)
                begin
                    start    <= 1'b0;
                    hold_cnt <= hold_cnt + 1;
                end
                // A drain waits until no answer is owed. A high done means the
                // monitor may still be taking the last answer at this edge, so
                // the wait also lasts while done is high. Either order of the
                // two processes then gives the same decision.
                else if (cmd_q[0].drain && (answer_q.size() != 0 || done || (start && !busy)))
                    start <= 1'b0;
                else
                begin
                    start    <= 1'b1;
                    op       <= cmd_q[0].opc;
                    key      <= cmd_q[0].arg;
                    hold_cnt <= 0;
                    cmd_q.delete(0);
                end
            end
        end
    end

    // Monitor. done lasts exactly one cycle and cannot be held off, so every
    // edge with done high carries one answer. It is checked against the
    // oldest answer still owed.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (answer_q.size() == 0)
            begin
                $display("%0t: answer with nothing expected: status %0d found %0d value %0d count %0d",
                         $time, status, found, value, count);
                errors++;
            end
            else
            begin
                if (status !== answer_q[0].st)
                begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, answer_q[0].st, status);
                    errors++;
                end
                if (found !== answer_q[0].hit)
                begin
                    $display("%0t: found mismatch, expected %0d, actual %0d",
                             $time, answer_q[0].hit, found);
                    errors++;
                end
                if (value !== answer_q[0].val)
                begin
                    $display("%0t: value mismatch, expected %0d, actual %0d",
                             $time, answer_q[0].val, value);
                    errors++;
                end
                if (count !== answer_q[0].cnt)
                begin
                    $display("%0t: count mismatch, expected %0d, actual %0d",
                             $time, answer_q[0].cnt, count);
                    errors++;
                end
                answer_q.delete(0);
            end
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin : stimulus
        int  made;
        int  burst_len;
        int  mode;
        int  r;
        bit  calm;
        logic [2:0] opc;

        // Directed part. It starts on the empty table, where every command
        // that needs a value has to fail. Then it checks the extreme keys,
        // duplicates, hits and misses, the unused codes, and clear.
        add_cmd(OP_POP,    '0,              0, 1'b0);
        add_cmd(OP_PEEK,   '0,              0, 1'b0);
        add_cmd(OP_REMOVE, 32'sd3,          1, 1'b0);
        add_cmd(OP_SEARCH, 32'sd3,          0, 1'b0);
        add_cmd(OP_INSERT, 32'sh7FFF_FFFF,  0, 1'b0);
        add_cmd(OP_INSERT, 32'sh8000_0000,  2, 1'b0);
        add_cmd(OP_INSERT, 32'sd0,          0, 1'b0);
        add_cmd(OP_INSERT, 32'sd0,          0, 1'b0);
        add_cmd(OP_INSERT, -32'sd1,         0, 1'b0);
        add_cmd(OP_PEEK,   '0,              0, 1'b0);
        add_cmd(OP_SEARCH, 32'sh8000_0000,  3, 1'b0);
        add_cmd(OP_SEARCH, 32'sd42,         0, 1'b0);
        add_cmd(OP_REMOVE, 32'sd0,          0, 1'b0);
        add_cmd(OP_SEARCH, 32'sd0,          0, 1'b0);
        add_cmd(OP_REMOVE, 32'sd42,         0, 1'b0);
        add_cmd(OP_POP,    '0,              0, 1'b0);
        add_cmd(OP_UNUSED_6, 32'sd5,        0, 1'b0);
        add_cmd(OP_UNUSED_7, -32'sd5,       1, 1'b0);
        add_cmd(OP_CLEAR,  '0,              0, 1'b0);
        add_cmd(OP_PEEK,   '0,              0, 1'b0);

        // Random part, built from bursts. A fill burst pushes the table up to
        // full, a mixed burst exercises everything, a drain burst empties the
        // table, and a clear burst clears it or sends an unused code. The
        // first burst is a fill of seventeen inserts. It waits for the
        // directed answers to drain, then overruns the table by one, so the
        // refusal on a full table happens early in every run.
        made = 0;
        for (int i = 0; i < TABLE_DEPTH + 1; i++)
        begin
            add_cmd(OP_INSERT, pick_key(), 0, i == 0);
            made++;
        end
        while (made < RANDOM_CMDS)
        begin
            mode = $urandom_range(0, 9);
            calm = ($urandom_range(0, 3) == 0);
            burst_len = $urandom_range(6, 24);
            for (int i = 0; i < burst_len; i++)
            begin
                r = $urandom_range(0, 99);
                if (mode <= 3)
                    opc = (r < 90) ? OP_INSERT : OP_SEARCH;
                else if (mode <= 6)
                begin
                    if (r < 30)      opc = OP_INSERT;
                    else if (r < 50) opc = OP_REMOVE;
                    else if (r < 70) opc = OP_SEARCH;
                    else if (r < 80) opc = OP_POP;
                    else if (r < 92) opc = OP_PEEK;
                    else if (r < 95) opc = OP_CLEAR;
                    else if (r < 97) opc = OP_UNUSED_6;
                    else             opc = OP_UNUSED_7;
                end
                else if (mode <= 8)
                begin
                    if (r < 40)      opc = OP_POP;
                    else if (r < 80) opc = OP_REMOVE;
                    else if (r < 90) opc = OP_PEEK;
                    else             opc = OP_SEARCH;
                end
                else
                begin
                    if (r < 60)      opc = OP_CLEAR;
                    else if (r < 80) opc = OP_UNUSED_6;
                    else             opc = OP_UNUSED_7;
                end
                add_cmd(opc, pick_key(), pick_gap(calm), $urandom_range(0, 99) == 0);
                made++;
            end
        end

        // Hold reset while the clock runs, then release it on a clock edge.
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every command has gone out and every answer has come
        // back. Then leave SETTLE_CYCLES quiet cycles for anything stray to appear.
        @(posedge clk);
        while (cmd_q.size() != 0 || start || answer_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (answer_q.size() != 0)
        begin
            $display("%0t: %0d answers never arrived", $time, answer_q.size());
            errors++;
        end
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
